[hdl/pdq_pkg.sv]
// Shared types and constants for the point deque block.
`timescale 1ns / 1ps

package pdq_pkg;

  localparam int COORD_W    = 32;
  localparam int IN_TDATA_W = 72;
  localparam int IN_TUSER_W = 3;
  localparam int OUT_TDATA_W = 64;
  localparam int OUT_TUSER_W = 2;

  typedef enum logic [2:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_CLEAR      = 3'd4,
    KIND_DUMP       = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ST_VALID = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    S_IDLE = 1'b0,
    S_DUMP = 1'b1
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    push_front;
    logic    push_back;
    logic    pop_front;
    logic    pop_back;
    logic    clear;
    logic    dump_start;
    logic    dump_read;
    logic    emit;
    status_t emit_status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic credit_ok;
    logic dump_last;
  } stat_t;

  // One result beat as held in the output queue.
  typedef struct packed {
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
    status_t            status;
    logic               last;
  } res_t;

endpackage

[hdl/pdq_ctrl.sv]
// Controller state machine of the point deque: decodes operations and sequences dumps.
`timescale 1ns / 1ps

module pdq_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  input  logic [pdq_pkg::IN_TUSER_W-1:0]    in_kind,
  output logic                              in_tready,
  input  pdq_pkg::stat_t                    stat,
  output pdq_pkg::cmd_t                     cmd
);

  pdq_pkg::state_t state_r;
  pdq_pkg::state_t state_nxt;
  pdq_pkg::kind_t  kind;
  logic            accept;

  assign kind   = pdq_pkg::kind_t'(in_kind);
  assign accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pdq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pdq_pkg::S_IDLE: begin
        if (accept && kind == pdq_pkg::KIND_DUMP && !stat.empty) begin
          state_nxt = pdq_pkg::S_DUMP;
        end
      end
      pdq_pkg::S_DUMP: begin
        if (stat.credit_ok && stat.dump_last) begin
          state_nxt = pdq_pkg::S_IDLE;
        end
      end
      default: state_nxt = pdq_pkg::S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd             = '0;
    cmd.emit_status = pdq_pkg::ST_VALID;
    in_tready       = 1'b0;
    case (state_r)
      pdq_pkg::S_IDLE: begin
        in_tready = stat.credit_ok;
        if (accept) begin
          case (kind)
            pdq_pkg::KIND_PUSH_FRONT,
            pdq_pkg::KIND_PUSH_BACK: begin
              if (stat.full) begin
                cmd.emit        = 1'b1;
                cmd.emit_status = pdq_pkg::ST_FULL;
              end else begin
                cmd.push_front = (kind == pdq_pkg::KIND_PUSH_FRONT);
                cmd.push_back  = (kind == pdq_pkg::KIND_PUSH_BACK);
              end
            end
            pdq_pkg::KIND_POP_FRONT: cmd.pop_front = !stat.empty;
            pdq_pkg::KIND_POP_BACK:  cmd.pop_back  = !stat.empty;
            pdq_pkg::KIND_CLEAR:     cmd.clear     = 1'b1;
            pdq_pkg::KIND_DUMP: begin
              if (stat.empty) begin
                cmd.emit        = 1'b1;
                cmd.emit_status = pdq_pkg::ST_EMPTY;
              end else begin
                cmd.dump_start = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      pdq_pkg::S_DUMP: begin
        cmd.dump_read = stat.credit_ok;
      end
      default: ;
    endcase
  end

endmodule

[hdl/pdq_dp.sv]
// Datapath of the point deque: ring store, pointers, read stage and output queue.
`timescale 1ns / 1ps

module pdq_dp #(
  parameter int DEPTH = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  pdq_pkg::cmd_t                      cmd,
  output pdq_pkg::stat_t                     stat,
  input  logic [pdq_pkg::COORD_W-1:0]        x_in,
  input  logic [pdq_pkg::COORD_W-1:0]        y_in,
  input  logic                               rev_in,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [pdq_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic [pdq_pkg::OUT_TUSER_W-1:0]    out_tuser,
  output logic                               out_tlast
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C   = CW'(DEPTH);
  localparam logic [PW:0]   DEPTH_S   = (PW + 1)'(DEPTH);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
  localparam int MW = 2 * pdq_pkg::COORD_W;

  function automatic logic [PW-1:0] ring_add(input logic [PW-1:0] base,
                                             input logic [PW-1:0] off);
    logic [PW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= DEPTH_S) begin
      sum = sum - DEPTH_S;
    end
    return sum[PW-1:0];
  endfunction

  // Ring store, contents undefined until written.
  logic [MW-1:0] mem [DEPTH];
  logic [MW-1:0] mem_rd_r;

  logic [PW-1:0] front_r, front_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [PW-1:0] idx_r, idx_nxt;
  logic          rev_r, rev_nxt;

  logic [CW-1:0] count_m1;
  logic [CW-1:0] dump_off;
  logic [PW-1:0] rd_addr;
  logic [PW-1:0] wr_addr;
  logic [PW-1:0] front_dec;
  logic          wr_en;

  // Read stage.
  logic             s1_valid_r;
  pdq_pkg::status_t s1_status_r, s1_status_nxt;
  logic             s1_last_r, s1_last_nxt;
  pdq_pkg::res_t    s1_res;

  // Two-entry output queue.
  pdq_pkg::res_t q_r [2];
  logic          q_wr_r, q_rd_r;
  logic [1:0]    q_cnt_r, q_cnt_nxt;
  logic [1:0]    occ;
  logic          pop;

  assign count_m1  = count_r - CW'(1);
  assign dump_off  = rev_r ? (count_m1 - CW'(idx_r)) : CW'(idx_r);
  assign rd_addr   = ring_add(front_r, dump_off[PW-1:0]);
  assign front_dec = (front_r == '0) ? LAST_SLOT : (front_r - PW'(1));
  assign wr_addr   = cmd.push_front ? front_dec : ring_add(front_r, count_r[PW-1:0]);
  assign wr_en     = cmd.push_front || cmd.push_back;

  assign stat.full      = (count_r == DEPTH_C);
  assign stat.empty     = (count_r == '0);
  assign stat.dump_last = (CW'(idx_r) == count_m1);
  assign pop            = out_tvalid && out_tready;
  assign occ            = q_cnt_r + {1'b0, s1_valid_r} - {1'b0, pop};
  assign stat.credit_ok = (occ < 2'd2);

  always_comb begin
    front_nxt = front_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    rev_nxt   = rev_r;
    if (cmd.clear) begin
      front_nxt = '0;
      count_nxt = '0;
    end
    if (cmd.push_front) begin
      front_nxt = front_dec;
      count_nxt = count_r + CW'(1);
    end
    if (cmd.push_back) begin
      count_nxt = count_r + CW'(1);
    end
    if (cmd.pop_front) begin
      front_nxt = ring_add(front_r, PW'(1));
      count_nxt = count_m1;
    end
    if (cmd.pop_back) begin
      count_nxt = count_m1;
    end
    if (cmd.dump_start) begin
      idx_nxt = '0;
      rev_nxt = rev_in;
    end
    if (cmd.dump_read) begin
      idx_nxt = idx_r + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
    end else begin
      front_r <= front_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    rev_r <= rev_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {y_in, x_in};
    end
    if (cmd.dump_read) begin
      mem_rd_r <= mem[rd_addr];
    end
  end

  always_comb begin
    if (cmd.emit) begin
      s1_status_nxt = cmd.emit_status;
      s1_last_nxt   = 1'b1;
    end else begin
      s1_status_nxt = pdq_pkg::ST_VALID;
      s1_last_nxt   = stat.dump_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= cmd.emit || cmd.dump_read;
    end
  end

  always_ff @(posedge clk) begin
    s1_status_r <= s1_status_nxt;
    s1_last_r   <= s1_last_nxt;
  end

  // Entry beats carry the stored point; status beats carry zeros.
  always_comb begin
    s1_res.status = s1_status_r;
    s1_res.last   = s1_last_r;
    if (s1_status_r == pdq_pkg::ST_VALID) begin
      s1_res.x = mem_rd_r[pdq_pkg::COORD_W-1:0];
      s1_res.y = mem_rd_r[MW-1:pdq_pkg::COORD_W];
    end else begin
      s1_res.x = '0;
      s1_res.y = '0;
    end
  end

  assign q_cnt_nxt = q_cnt_r + {1'b0, s1_valid_r} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_cnt_r <= '0;
      q_wr_r  <= 1'b0;
      q_rd_r  <= 1'b0;
    end else begin
      q_cnt_r <= q_cnt_nxt;
      if (s1_valid_r) begin
        q_wr_r <= ~q_wr_r;
      end
      if (pop) begin
        q_rd_r <= ~q_rd_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      q_r[q_wr_r] <= s1_res;
    end
  end

  assign out_tvalid = (q_cnt_r != '0);
  assign out_tdata  = {q_r[q_rd_r].y, q_r[q_rd_r].x};
  assign out_tuser  = q_r[q_rd_r].status;
  assign out_tlast  = q_r[q_rd_r].last;

endmodule

[hdl/point_deque_with_dump.sv]
// Top level of the point deque with dump: controller plus datapath.
// Push, pop and clear update the deque on acceptance; the input is open for a new beat while the output queue has room.
// A full push or empty dump gives a single result beat, registered in the read stage and then in the output queue.
// A dump blocks input until its last entry is read, streaming one beat a cycle while the output
// queue has room, through the single read port of the ring store and the read register.
// Synchronous active-low reset empties the deque and output queue; store contents stay.
`timescale 1ns / 1ps

// Operation of the block:
// Each input beat is one deque operation, selected by in_tuser. The ring store is a
// single-port memory of DEPTH points addressed relative to a front pointer; the entry
// count locates the back. A dump walks the live entries in order, one read per cycle,
// and each read goes through one register stage into a two-entry output queue. The
// controller issues a read or result only when the queue is sure to have room, so a
// stalled output never loses a beat and the input is still taken while a result waits.
module point_deque_with_dump #(
  parameter int DEPTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // in_tdata: [31:0] x_coord, [63:32] y_coord, [64] reverse_order, [71:65] zero
  input  logic [pdq_pkg::IN_TDATA_W-1:0]    in_tdata,
  // in_tuser: [2:0] kind
  input  logic [pdq_pkg::IN_TUSER_W-1:0]    in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // out_tdata: [31:0] out_x, [63:32] out_y
  output logic [pdq_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // out_tuser: [1:0] status
  output logic [pdq_pkg::OUT_TUSER_W-1:0]   out_tuser,
  output logic                              out_tlast
);

  pdq_pkg::cmd_t  cmd;
  pdq_pkg::stat_t stat;

  pdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_kind   (in_tuser),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The padding bits above reverse_order are not used.
  pdq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .x_in       (in_tdata[pdq_pkg::COORD_W-1:0]),
    .y_in       (in_tdata[2*pdq_pkg::COORD_W-1:pdq_pkg::COORD_W]),
    .rev_in     (in_tdata[2*pdq_pkg::COORD_W]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

[hdl/pdq_checker.sv]
// Port-level checker for the point deque, bound to the top level.
`timescale 1ns / 1ps

module pdq_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [pdq_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input logic [pdq_pkg::OUT_TUSER_W-1:0]   out_tuser,
  input logic                              out_tlast
);

  // Reset leaves no result pending and the input open.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("output not idle or input closed after reset");

  // Status beats (empty dump, dropped push) end their run and carry no point.
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != pdq_pkg::ST_VALID |-> out_tlast && out_tdata == '0)
    else $error("status beat without last or with nonzero data");

  // Only the three defined status codes are ever shown.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser == pdq_pkg::ST_VALID || out_tuser == pdq_pkg::ST_EMPTY ||
                   out_tuser == pdq_pkg::ST_FULL)
    else $error("undefined status code on output");

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
                                  $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled output beat changed");

endmodule

bind point_deque_with_dump pdq_checker u_pdq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

[tb/sv/point_deque_with_dump_test.sv]
// Self-checking testbench for the point deque with dump block.
`timescale 1ns / 1ps

module point_deque_with_dump_test;
  import pdq_pkg::*;

  localparam int DEPTH = 32;
  // Give up on the run after this many clock cycles; a correct run needs far fewer.
  localparam int CYCLE_LIMIT = 400000;
  // Length of the single long receiver hold-off used to back the block up.
  localparam int LONG_HOLD_CYCLES = 400;
  // Cycles to keep watching the output after the last expected beat has arrived.
  localparam int DRAIN_CYCLES = 40;
  // Kind codes the block has no operation for; they must be ignored.
  localparam logic [2:0] KIND_SPARE_6 = 3'd6;
  localparam logic [2:0] KIND_SPARE_7 = 3'd7;

  // One operation waiting to be offered on the input stream.
  typedef struct {
    logic [2:0]  kind;
    logic [31:0] x;
    logic [31:0] y;
    logic        rev;
  } deque_op_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  // in_tdata: [31:0] x_coord, [63:32] y_coord, [64] reverse_order, [71:65] zero
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  // in_tuser: [2:0] kind
  logic [IN_TUSER_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  // out_tdata: [31:0] out_x, [63:32] out_y
  logic [OUT_TDATA_W-1:0] out_tdata;
  // out_tuser: [1:0] status
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic out_tlast;

  point_deque_with_dump #(
    .DEPTH(DEPTH)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .out_tlast(out_tlast)
  );

  always #2 clk = ~clk;

  // Stimulus bookkeeping. The driver counts beats it puts on the bus and the
  // monitor counts beats the block takes; when the two agree the bus is free.
  deque_op_t pending_ops[$];
  deque_op_t next_op;
  int ops_offered = 0;
  int ops_taken = 0;
  int items_queued = 0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int cycle_count = 0;
  int mismatch_count = 0;

  // Predicted deque contents and the result beats still owed by the block.
  logic [31:0] ring_x[DEPTH];
  logic [31:0] ring_y[DEPTH];
  int head_slot = 0;
  int held_count = 0;
  res_t expected_beats[$];

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  task automatic expect_beat(input logic [31:0] x, input logic [31:0] y,
                             input status_t status, input logic last);
    res_t beat;
    beat.x = x;
    beat.y = y;
    beat.status = status;
    beat.last = last;
    expected_beats.push_back(beat);
  endtask

  // Apply one accepted operation to the predicted deque and queue the beats it
  // must produce. The ring wraps modulo DEPTH; the back is front plus count.
  task automatic apply_deque_op(input logic [2:0] kind, input logic [31:0] x,
                                input logic [31:0] y, input logic rev);
    int slot;
    int i;
    case (kind)
      KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
        if (held_count >= DEPTH) begin
          // A push into a full deque is dropped and reported in one beat.
          expect_beat('0, '0, ST_FULL, 1'b1);
        end else begin
          if (kind == KIND_PUSH_FRONT) begin
            head_slot = (head_slot + DEPTH - 1) % DEPTH;
            slot = head_slot;
          end else begin
            slot = (head_slot + held_count) % DEPTH;
          end
          ring_x[slot] = x;
          ring_y[slot] = y;
          held_count++;
        end
      end
      KIND_POP_FRONT: begin
        if (held_count > 0) begin
          head_slot = (head_slot + 1) % DEPTH;
          held_count--;
        end
      end
      KIND_POP_BACK: begin
        if (held_count > 0) held_count--;
      end
      KIND_CLEAR: begin
        held_count = 0;
        head_slot = 0;
      end
      KIND_DUMP: begin
        if (held_count == 0) begin
          expect_beat('0, '0, ST_EMPTY, 1'b1);
        end else begin
          for (i = 0; i < held_count; i++) begin
            slot = (head_slot + (rev ? held_count - 1 - i : i)) % DEPTH;
            expect_beat(ring_x[slot], ring_y[slot], ST_VALID, i == held_count - 1);
          end
        end
      end
      default: begin
        // Spare kind codes leave the deque untouched and give no beat.
      end
    endcase
  endtask

  // Compare one accepted output beat with the oldest prediction, field by field.
  task automatic check_result_beat();
    res_t want;
    if (expected_beats.size() == 0) begin
      report_mismatch($sformatf("unexpected beat x=%h y=%h status=%0d last=%b",
                                out_tdata[31:0], out_tdata[63:32], out_tuser, out_tlast));
    end else begin
      want = expected_beats.pop_front();
      if (out_tdata[31:0] !== want.x)
        report_mismatch($sformatf("out_x %h, expected %h", out_tdata[31:0], want.x));
      if (out_tdata[63:32] !== want.y)
        report_mismatch($sformatf("out_y %h, expected %h", out_tdata[63:32], want.y));
      if (out_tuser !== want.status)
        report_mismatch($sformatf("status %0d, expected %0d", out_tuser, want.status));
      if (out_tlast !== want.last)
        report_mismatch($sformatf("tlast %b, expected %b", out_tlast, want.last));
    end
  endtask

  task automatic queue_op(input logic [2:0] kind, input logic [31:0] x,
                          input logic [31:0] y, input logic rev);
    deque_op_t op;
    op.kind = kind;
    op.x = x;
    op.y = y;
    op.rev = rev;
    pending_ops.push_back(op);
    items_queued++;
  endtask

  // Queue one short random sequence. Filling the deque takes a long run of
  // pushes, so most of the traffic is shaped: fill runs that may overflow and then
  // dump, drain runs that may pop past empty, clear then dump, and a mixed stream of everything.
  task automatic queue_random_burst(input bit force_fill);
    int pick;
    int n;
    int i;
    int r;
    logic [2:0] kind;
    pick = force_fill ? 0 : $urandom_range(0, 9);
    if (pick <= 2) begin
      n = force_fill ? $urandom_range(33, 36) : $urandom_range(20, 36);
      for (i = 0; i < n; i++)
        queue_op($urandom_range(0, 1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT,
                 $urandom, $urandom, $urandom_range(0, 1));
      queue_op(KIND_DUMP, $urandom, $urandom, $urandom_range(0, 1));
    end else if (pick <= 4) begin
      n = $urandom_range(5, 36);
      for (i = 0; i < n; i++)
        queue_op($urandom_range(0, 1) ? KIND_POP_BACK : KIND_POP_FRONT,
                 $urandom, $urandom, $urandom_range(0, 1));
      queue_op(KIND_DUMP, $urandom, $urandom, $urandom_range(0, 1));
    end else if (pick == 9) begin
      queue_op(KIND_CLEAR, $urandom, $urandom, $urandom_range(0, 1));
      queue_op(KIND_DUMP, $urandom, $urandom, $urandom_range(0, 1));
    end else begin
      n = $urandom_range(4, 12);
      for (i = 0; i < n; i++) begin
        r = $urandom_range(0, 99);
        if (r < 25) kind = KIND_PUSH_FRONT;
        else if (r < 50) kind = KIND_PUSH_BACK;
        else if (r < 62) kind = KIND_POP_FRONT;
        else if (r < 74) kind = KIND_POP_BACK;
        else if (r < 78) kind = KIND_CLEAR;
        else if (r < 94) kind = KIND_DUMP;
        else kind = $urandom_range(0, 1) ? KIND_SPARE_7 : KIND_SPARE_6;
        queue_op(kind, $urandom, $urandom, $urandom_range(0, 1));
      end
    end
  endtask

  // Block until every queued operation has been taken by the block.
  task automatic wait_ops_taken();
    while (pending_ops.size() != 0 || ops_offered != ops_taken) @(posedge clk);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int n_items);
    int target;
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    target = items_queued + n_items;
    while (items_queued < target) queue_random_burst(1'b0);
    wait_ops_taken();
  endtask

  // Input driver: runs on the falling edge. A beat on the bus stays until the
  // monitor has seen it taken; only then may the next one or an idle follow.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (ops_offered == ops_taken) begin
      if (pending_ops.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        next_op = pending_ops.pop_front();
        in_tvalid <= 1'b1;
        in_tuser <= next_op.kind;
        in_tdata <= {7'b0, next_op.rev, next_op.y, next_op.x};
        ops_offered <= ops_offered + 1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Output ready: random stalls at the phase rate, or a long hold-off when the
  // stimulus asks for one so the block backs up and stalls its input.
  always @(negedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served <= hold_requests;
      hold_left <= LONG_HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= $urandom_range(0, 99) >= receiver_stall_pct;
    end
  end

  // Monitor: on each rising edge, predict from an accepted input beat and
  // check an accepted output beat. No result can follow its cause within the
  // same cycle, so the order of the two steps does not matter.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        apply_deque_op(in_tuser, in_tdata[31:0], in_tdata[63:32], in_tdata[64]);
        ops_taken <= ops_taken + 1;
      end
      if (out_tvalid && out_tready) check_result_beat();
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d beats still expected",
               cycle_count, expected_beats.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: empty dumps in both orders, pops on an empty deque,
    // extreme coordinates at both ends, dumps both ways, the spare codes,
    // popping the only entry from either end, and clear.
    queue_op(KIND_DUMP, 32'h0, 32'h0, 1'b0);
    queue_op(KIND_DUMP, 32'h0, 32'h0, 1'b1);
    queue_op(KIND_POP_FRONT, 32'h0, 32'h0, 1'b0);
    queue_op(KIND_POP_BACK, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1);
    queue_op(KIND_PUSH_BACK, 32'h7FFFFFFF, 32'h80000000, 1'b0);
    queue_op(KIND_PUSH_FRONT, 32'h80000000, 32'h7FFFFFFF, 1'b1);
    queue_op(KIND_PUSH_BACK, 32'hFFFFFFFF, 32'h00000000, 1'b0);
    queue_op(KIND_PUSH_FRONT, 32'h00000000, 32'hFFFFFFFF, 1'b0);
    queue_op(KIND_DUMP, 32'h0, 32'h0, 1'b0);
    queue_op(KIND_DUMP, 32'h0, 32'h0, 1'b1);
    queue_op(KIND_SPARE_6, 32'h12345678, 32'h9ABCDEF0, 1'b1);
    queue_op(KIND_SPARE_7, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1);
    queue_op(KIND_POP_FRONT, 32'h0, 32'h0, 1'b0);
    queue_op(KIND_POP_BACK, 32'h0, 32'h0, 1'b0);
    queue_op(KIND_DUMP, 32'h0, 32'h0, 1'b1);
    queue_op(KIND_POP_FRONT, 32'h0, 32'h0, 1'b0);
    queue_op(KIND_POP_BACK, 32'h0, 32'h0, 1'b0);
    queue_op(KIND_DUMP, 32'h0, 32'h0, 1'b0);
    queue_op(KIND_PUSH_FRONT, 32'h00000001, 32'hFFFFFFFE, 1'b0);
    queue_op(KIND_POP_FRONT, 32'h0, 32'h0, 1'b0);
    queue_op(KIND_DUMP, 32'h0, 32'h0, 1'b1);
    queue_op(KIND_PUSH_BACK, 32'hA5A5A5A5, 32'h5A5A5A5A, 1'b0);
    queue_op(KIND_CLEAR, 32'h0, 32'h0, 1'b0);
    queue_op(KIND_PUSH_FRONT, 32'h5A5A5A5A, 32'hA5A5A5A5, 1'b0);
    queue_op(KIND_DUMP, 32'h0, 32'h0, 1'b0);
    wait_ops_taken();

    // Random part. The first phase opens with a run that overflows the deque.
    queue_random_burst(1'b1);
    run_phase(0, 0, 16);

    // Hold the output off for a long stretch while the input keeps coming,
    // with a full deque dumped several times so the block has to stall.
    hold_requests++;
    queue_random_burst(1'b1);
    queue_op(KIND_DUMP, $urandom, $urandom, 1'b0);
    queue_op(KIND_DUMP, $urandom, $urandom, 1'b1);
    queue_op(KIND_PUSH_BACK, $urandom, $urandom, 1'b0);
    wait_ops_taken();

    run_phase(78, 0, 16);
    run_phase(0, 78, 16);
    run_phase(22, 22, 16);

    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_beats.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[files.f]
hdl/pdq_pkg.sv
hdl/pdq_ctrl.sv
hdl/pdq_dp.sv
hdl/point_deque_with_dump.sv
hdl/pdq_checker.sv
tb/sv/point_deque_with_dump_test.sv
